// File: rtl/lehmer_random_draw_unit_core_defines.svh
// Assertion macros for the Lehmer draw unit.
// Used by the top level; the macros expect clk_i and rst_ni in scope.
`ifndef LEHMER_RANDOM_DRAW_UNIT_CORE_DEFINES_SVH
`define LEHMER_RANDOM_DRAW_UNIT_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LRD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lrd_pkg.sv
// Shared types and constants for the Lehmer draw unit.
// No dependencies; used by lrd_mulred and lehmer_random_draw_unit_core.
`timescale 1ns / 1ps
`default_nettype none

package lrd_pkg;

  localparam int unsigned STATE_W  = 31;
  localparam int unsigned OPB_W    = 16;
  localparam int unsigned PROD_W   = STATE_W + OPB_W;
  localparam int unsigned QUOT_W   = OPB_W + 1;
  localparam int unsigned VALUE_W  = 32;

  // Modulus 2^31 - 1 and the minimal-standard multiplier
  localparam logic [STATE_W-1:0] MODULUS    = {STATE_W{1'b1}};
  localparam logic [OPB_W-1:0]   MULTIPLIER = 16'd16807;

  typedef enum logic [1:0] {
    MODE_RAW   = 2'd0,
    MODE_RANGE = 2'd1,
    MODE_BERN  = 2'd2,
    MODE_SKIP  = 2'd3
  } lrd_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RED,
    ST_SPAN_MUL,
    ST_SPAN_RED,
    ST_DONE
  } lrd_state_e;

  // Result of reducing a product by the modulus
  typedef struct packed {
    logic [STATE_W-1:0] residue;
    logic [QUOT_W-1:0]  quot;
  } lrd_red_t;

endpackage

`default_nettype wire

// File: rtl/lrd_mulred.sv
// Shared multiply and reduce unit: registered 31x16 product, then mod 2^31-1.
// Depends on lrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lrd_mulred
  import lrd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic [STATE_W-1:0] a_i,
  input  wire logic [OPB_W-1:0]   b_i,
  output lrd_red_t                red_o
);

  logic [PROD_W-1:0]  prod_q;
  logic [PROD_W-1:0]  prod_d;
  logic [OPB_W-1:0]   hi;
  logic [STATE_W-1:0] lo;
  logic [STATE_W:0]   fold;
  logic               wrap;

  // Multiply; the product is registered every cycle
  assign prod_d = PROD_W'(a_i) * PROD_W'(b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // Fold: 2^31 == 1 mod M, so p = hi*M + (hi + lo), and hi + lo < 2M
  assign hi   = prod_q[PROD_W-1:STATE_W];
  assign lo   = prod_q[STATE_W-1:0];
  assign fold = (STATE_W+1)'(hi) + (STATE_W+1)'(lo);
  assign wrap = (fold >= {1'b0, MODULUS});

  always_comb begin
    red_o.residue = wrap ? STATE_W'(fold - {1'b0, MODULUS}) : fold[STATE_W-1:0];
    red_o.quot    = QUOT_W'(hi) + QUOT_W'(wrap);
  end

endmodule

`default_nettype wire

// File: rtl/lehmer_random_draw_unit_core.sv
// Lehmer minimal-standard draw unit: state' = 16807 * state mod (2^31 - 1).
// One word is taken at a time and the unit stalls its input until the result
// is in the output register. Raw and Bernoulli draws go through accept,
// multiply, reduce and hand to output; a range draw adds a second pass of
// the shared multiplier that scales by range_max, and a skip of n steps runs
// multiply and reduce n times. All arithmetic runs through one 31x16
// multiplier with a registered product and an end-around fold that reduces
// mod 2^31 - 1 with a single compare and subtract. A seed write loads the
// state directly. No clearing pass is needed after reset.
// Depends on lrd_pkg, lrd_mulred and lehmer_random_draw_unit_core_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "lehmer_random_draw_unit_core_defines.svh"

module lehmer_random_draw_unit_core
  import lrd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // seed register
  input  wire logic               cfg_we_i,
  input  wire logic [STATE_W-1:0] cfg_wdata_i,
  // input words
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         mode_i,
  input  wire logic [15:0]        range_max_i,
  input  wire logic signed [15:0] range_min_i,
  input  wire logic [STATE_W-1:0] prob_threshold_i,
  input  wire logic [15:0]        skip_count_i,
  // output words
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [VALUE_W-1:0] value_o
);

  lrd_state_e          fsm_q, fsm_d;
  logic [STATE_W-1:0]  gen_state_q, gen_state_d;
  lrd_mode_e           mode_q, mode_d;
  logic [OPB_W-1:0]    rmax_q, rmax_d;
  logic [15:0]         rmin_q, rmin_d;
  logic [STATE_W-1:0]  thr_q, thr_d;
  logic [15:0]         cnt_q, cnt_d;
  logic [VALUE_W-1:0]  res_q, res_d;
  logic                out_valid_q, out_valid_d;
  logic [VALUE_W-1:0]  value_q, value_d;
  logic                accept;
  logic                out_free;
  logic [OPB_W-1:0]    opb;
  lrd_red_t            red;

  // Take a word only while idle
  assign in_stall_o = (fsm_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Shared multiplier: generator step or span scaling
  assign opb = (fsm_q == ST_SPAN_MUL) ? rmax_q : MULTIPLIER;

  lrd_mulred u_mulred (
    .clk_i (clk_i),
    .a_i   (gen_state_q),
    .b_i   (opb),
    .red_o (red)
  );

  // Sequencer
  always_comb begin
    fsm_d       = fsm_q;
    gen_state_d = gen_state_q;
    mode_d      = mode_q;
    rmax_d      = rmax_q;
    rmin_d      = rmin_q;
    thr_d       = thr_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    value_d     = value_q;

    // drop the output word once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (fsm_q)
      ST_IDLE: begin
        if (accept) begin
          mode_d = lrd_mode_e'(mode_i);
          rmax_d = range_max_i;
          rmin_d = range_min_i;
          thr_d  = prob_threshold_i;
          cnt_d  = skip_count_i;
          if (lrd_mode_e'(mode_i) == MODE_SKIP && skip_count_i == 16'd0) begin
            res_d = VALUE_W'(gen_state_q);
            fsm_d = ST_DONE;
          end else begin
            fsm_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        fsm_d = ST_RED;
      end
      ST_RED: begin
        gen_state_d = red.residue;
        case (mode_q)
          MODE_RAW: begin
            res_d = VALUE_W'(red.residue);
            fsm_d = ST_DONE;
          end
          MODE_RANGE: begin
            fsm_d = ST_SPAN_MUL;
          end
          MODE_BERN: begin
            res_d = VALUE_W'(red.residue < thr_q);
            fsm_d = ST_DONE;
          end
          MODE_SKIP: begin
            cnt_d = cnt_q - 16'd1;
            if (cnt_q == 16'd1) begin
              res_d = VALUE_W'(red.residue);
              fsm_d = ST_DONE;
            end else begin
              fsm_d = ST_MUL;
            end
          end
          default: begin
            fsm_d = ST_DONE;
          end
        endcase
      end
      ST_SPAN_MUL: begin
        fsm_d = ST_SPAN_RED;
      end
      ST_SPAN_RED: begin
        // floor(state * range_max / M) + range_min
        res_d = VALUE_W'(red.quot) + VALUE_W'(signed'(rmin_q));
        fsm_d = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          value_d     = res_q;
          out_valid_d = 1'b1;
          fsm_d       = ST_IDLE;
        end
      end
      default: begin
        fsm_d = ST_IDLE;
      end
    endcase

    // seed write loads the generator
    if (cfg_we_i) begin
      gen_state_d = cfg_wdata_i;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= ST_IDLE;
      gen_state_q <= STATE_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      fsm_q       <= fsm_d;
      gen_state_q <= gen_state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    rmax_q  <= rmax_d;
    rmin_q  <= rmin_d;
    thr_q   <= thr_d;
    cnt_q   <= cnt_d;
    res_q   <= res_d;
    value_q <= value_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = signed'(value_q);

  // Checks
  `LRD_ASSERT_NEXT(a_state_reduced, fsm_q == ST_RED && !cfg_we_i, gen_state_q != MODULUS, "state not reduced below modulus")
  `LRD_ASSERT_NOW(a_span_bound, fsm_q == ST_SPAN_RED, red.quot <= QUOT_W'(rmax_q), "range quotient exceeds span")
  `LRD_ASSERT_NOW(a_out_from_done, $rose(out_valid_o), $past(fsm_q) == ST_DONE, "output word without finished draw")
  `LRD_ASSERT_NEXT(a_zero_skip, accept && mode_i == MODE_SKIP && skip_count_i == 16'd0, fsm_q == ST_DONE && res_q == VALUE_W'($past(gen_state_q)), "zero skip must return current state")

endmodule

`default_nettype wire

// File: dv/tb_lehmer_random_draw_unit_core.sv
// Self-checking testbench for lehmer_random_draw_unit_core.
// Runs a directed table, then random draws under several seeds, and checks
// each output word against a built-in predictor or a value from the table. Depends on lrd_pkg.
`timescale 1ns / 1ps

module tb_lehmer_random_draw_unit_core;
  import lrd_pkg::*;

  localparam int unsigned DEAD_LIMIT = 500_000;  // cycles with no word moving
  localparam int unsigned SKIP_CAP   = 65535;
  localparam int unsigned PHASES     = 6;
  localparam int unsigned PHASE_LEN  = 200;

  typedef struct {
    lrd_mode_e          mode;
    logic [15:0]        span;
    logic signed [15:0] offset;
    logic [30:0]        thresh;
    logic [15:0]        steps;
  } draw_t;

  typedef struct {
    bit          is_seed;
    logic [30:0] seed;
    draw_t       d;
    bit          typed;
    logic [31:0] want;
  } plan_row_t;

  logic                clk_i            = 1'b0;
  logic                rst_ni           = 1'b0;
  logic                cfg_we_i         = 1'b0;
  logic [30:0]         cfg_wdata_i      = '0;
  logic                in_valid_i       = 1'b0;
  logic                in_stall_o;
  logic [1:0]          mode_i           = '0;
  logic [15:0]         range_max_i      = '0;
  logic signed [15:0]  range_min_i      = '0;
  logic [30:0]         prob_threshold_i = '0;
  logic [15:0]         skip_count_i     = '0;
  logic                out_valid_o;
  logic                out_stall_i      = 1'b0;
  logic signed [31:0]  value_o;

  logic [30:0]  lehmer_state = 31'd1;
  logic [31:0]  value_queue[$];
  plan_row_t    plan_q[$];
  bit           no_idle = 1'b0;
  int unsigned  err_count = 0;
  int unsigned  words_checked = 0;
  int unsigned  seed_loads = 0;
  int unsigned  mode_hits[4];
  int unsigned  stall_run = 0;

  lehmer_random_draw_unit_core uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .range_max_i      (range_max_i),
    .range_min_i      (range_min_i),
    .prob_threshold_i (prob_threshold_i),
    .skip_count_i     (skip_count_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .value_o          (value_o)
  );

  always #5 clk_i = ~clk_i;

  // (a * b) mod 2^31-1, exact in 64 bits since both factors are reduced first
  function automatic logic [30:0] mod_mul(longint unsigned a, longint unsigned b);
    longint unsigned m = 64'(MODULUS);
    return 31'(((a % m) * (b % m)) % m);
  endfunction

  // Jump the generator n steps: s * 16807^n mod 2^31-1
  function automatic logic [30:0] lehmer_jump(logic [30:0] s, int unsigned n);
    longint unsigned acc;
    longint unsigned base;
    int unsigned     k;
    if (n == 0) return s;
    acc  = 64'd1;
    base = 64'(MULTIPLIER);
    k    = n;
    while (k != 0) begin
      if ((k & 1) != 0) acc = 64'(mod_mul(acc, base));
      base = 64'(mod_mul(base, base));
      k = k >> 1;
    end
    return mod_mul(acc, 64'(s));
  endfunction

  // Advance the predicted state for one draw and return the output word
  function automatic logic [31:0] predict_draw(draw_t d);
    longint unsigned q;
    int              r;
    logic [31:0]     v;
    if (d.mode == MODE_SKIP) begin
      lehmer_state = lehmer_jump(lehmer_state,
                                 (d.steps > SKIP_CAP) ? SKIP_CAP : int'(d.steps));
      v = {1'b0, lehmer_state};
    end else begin
      lehmer_state = mod_mul(64'(MULTIPLIER), 64'(lehmer_state));
      case (d.mode)
        MODE_RAW: begin
          v = {1'b0, lehmer_state};
        end
        MODE_RANGE: begin
          q = (64'(lehmer_state) * 64'(d.span)) / 64'(MODULUS);
          r = int'(q) + int'(d.offset);
          v = r;
        end
        default: begin
          v = (lehmer_state < d.thresh) ? 32'd1 : 32'd0;
        end
      endcase
    end
    return v;
  endfunction

  // Idle length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic draw_t random_draw();
    draw_t       d;
    int unsigned r;
    d.mode = lrd_mode_e'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0:       d.span = 16'h0000;
      1:       d.span = 16'hFFFF;
      default: d.span = 16'($urandom);
    endcase
    d.offset = 16'($urandom);
    case ($urandom_range(0, 9))
      0:       d.thresh = 31'h0;
      1:       d.thresh = 31'h7FFF_FFFF;
      default: d.thresh = 31'($urandom);
    endcase
    // Skips take a multiply and a reduce per step: keep most short, a rare one full width
    if (d.mode == MODE_SKIP) begin
      r = $urandom_range(0, 99);
      if (r < 85)      d.steps = 16'($urandom_range(0, 15));
      else if (r < 99) d.steps = 16'($urandom_range(16, 1023));
      else             d.steps = 16'($urandom);
    end else begin
      d.steps = 16'($urandom);
    end
    return d;
  endfunction

  function automatic void plan_seed(logic [30:0] v);
    plan_row_t row;
    row.is_seed = 1'b1;
    row.seed    = v;
    row.typed   = 1'b0;
    row.want    = '0;
    plan_q = {plan_q, row};
  endfunction

  function automatic void plan_draw(lrd_mode_e m, logic [15:0] span,
                                    logic signed [15:0] offset, logic [30:0] thresh,
                                    logic [15:0] steps, bit typed, logic [31:0] want);
    plan_row_t row;
    row.is_seed  = 1'b0;
    row.seed     = '0;
    row.d.mode   = m;
    row.d.span   = span;
    row.d.offset = offset;
    row.d.thresh = thresh;
    row.d.steps  = steps;
    row.typed    = typed;
    row.want     = want;
    plan_q = {plan_q, row};
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    err_count++;
    $display("%0t ns: %s: got %0d (0x%08h), want %0d (0x%08h)",
             $time, what, $signed(got), got, $signed(want), want);
  endtask

  // Hold off the sender until every expected word is back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (value_queue.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic load_seed(logic [30:0] v);
    wait_drained();
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    lehmer_state = v;
    seed_loads++;
  endtask

  // Present one input word, hold it until accepted, then queue its result
  task automatic send_draw(draw_t d, bit typed, logic [31:0] want);
    int unsigned gap;
    logic [31:0] predicted;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    mode_i           <= d.mode;
    range_max_i      <= d.span;
    range_min_i      <= d.offset;
    prob_threshold_i <= d.thresh;
    skip_count_i     <= d.steps;
    in_valid_i       <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predicted = predict_draw(d);
    value_queue = {value_queue, (typed ? want : predicted)};
    mode_hits[d.mode]++;
  endtask

  // Output side: check accepted words, then pick the next stall
  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (value_queue.size() == 0) begin
          report_mismatch("output word with nothing expected", value_o, '0);
        end else begin
          want = value_queue.pop_front();
          if (value_o !== want) report_mismatch("value mismatch", value_o, want);
          else words_checked++;
        end
      end
      if (stall_run != 0) begin
        out_stall_i <= 1'b1;
        stall_run = stall_run - 1;
      end else begin
        stall_run = pick_gap();
        out_stall_i <= (stall_run != 0);
        if (stall_run != 0) stall_run = stall_run - 1;
      end
    end
  end

  // Watchdog: end the run if no word moves on either side for too long
  initial begin
    int unsigned dead_cycles;
    dead_cycles = 0;
    while (dead_cycles < DEAD_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) dead_cycles = 0;
      else dead_cycles++;
    end
    $display("Timeout: no word moved for %0d cycles", DEAD_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    logic [30:0] seed_v;
    foreach (mode_hits[i]) mode_hits[i] = 0;

    // Directed table: state starts at 1 after reset
    //        mode        span      offset      thresh         steps  typed want
    plan_draw(MODE_RAW,   16'h0000, 16'sh0000, 31'h0,         16'd0,     1, 32'd16807);
    plan_draw(MODE_RAW,   16'hFFFF, 16'shFFFF, 31'h7FFF_FFFF, 16'hFFFF,  1, 32'd282475249);
    plan_draw(MODE_RAW,   16'h0000, 16'sh0000, 31'h0,         16'd0,     1, 32'd1622650073);
    plan_draw(MODE_RANGE, 16'h0000, 16'sh8000, 31'h0,         16'd0,     1, 32'hFFFF_8000);
    plan_draw(MODE_RANGE, 16'hFFFF, 16'sh7FFF, 31'h0,         16'd0,     0, '0);
    plan_draw(MODE_RANGE, 16'hFFFF, 16'sh8000, 31'h0,         16'd0,     0, '0);
    plan_draw(MODE_RANGE, 16'h1234, -16'sd5,   31'h0,         16'd0,     0, '0);
    plan_draw(MODE_BERN,  16'h0000, 16'sh0000, 31'h0,         16'd0,     1, 32'd0);
    plan_draw(MODE_BERN,  16'h0000, 16'sh0000, 31'h7FFF_FFFF, 16'd0,     1, 32'd1);
    plan_draw(MODE_BERN,  16'h0000, 16'sh0000, 31'h4000_0000, 16'd0,     0, '0);
    plan_draw(MODE_SKIP,  16'h0000, 16'sh0000, 31'h0,         16'd0,     0, '0);
    plan_draw(MODE_SKIP,  16'h0000, 16'sh0000, 31'h0,         16'd1,     0, '0);
    plan_draw(MODE_SKIP,  16'h0000, 16'sh0000, 31'h0,         16'hFFFF,  0, '0);
    // Largest legal seed steps to -16807 mod M
    plan_seed(31'h7FFF_FFFE);
    plan_draw(MODE_RAW,   16'h0000, 16'sh0000, 31'h0,         16'd0,     1, 32'd2147466840);
    // Zero seed stays at zero
    plan_seed(31'h0);
    plan_draw(MODE_RAW,   16'h0000, 16'sh0000, 31'h0,         16'd0,     1, 32'd0);
    plan_draw(MODE_SKIP,  16'h0000, 16'sh0000, 31'h0,         16'd300,   1, 32'd0);
    plan_draw(MODE_BERN,  16'h0000, 16'sh0000, 31'h1,         16'd0,     1, 32'd1);
    plan_draw(MODE_RANGE, 16'hFFFF, 16'sh7FFF, 31'h0,         16'd0,     1, 32'd32767);
    // Seed equal to the modulus: held by a zero skip, drops to zero on a step
    plan_seed(31'h7FFF_FFFF);
    plan_draw(MODE_SKIP,  16'h0000, 16'sh0000, 31'h0,         16'd0,     1, 32'd2147483647);
    plan_draw(MODE_RAW,   16'h0000, 16'sh0000, 31'h0,         16'd0,     1, 32'd0);
    plan_seed(31'h7FFF_FFFF);
    plan_draw(MODE_SKIP,  16'h0000, 16'sh0000, 31'h0,         16'd5,     1, 32'd0);
    plan_seed(31'h7FFF_FFFF);
    plan_draw(MODE_BERN,  16'h0000, 16'sh0000, 31'h7FFF_FFFF, 16'd0,     1, 32'd1);
    // Back to seed 1: two steps land on the second value of the sequence
    plan_seed(31'd1);
    plan_draw(MODE_SKIP,  16'h0000, 16'sh0000, 31'h0,         16'd2,     1, 32'd282475249);
    plan_draw(MODE_RANGE, 16'h0001, 16'sh0000, 31'h0,         16'd0,     1, 32'd0);

    // Reset, then release on a clock edge
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan_q[i]) begin
      if (plan_q[i].is_seed) load_seed(plan_q[i].seed);
      else send_draw(plan_q[i].d, plan_q[i].typed, plan_q[i].want);
    end

    // Random phases, each under its own seed; one runs with no idling
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       seed_v = 31'h7FFF_FFFE;
        1:       seed_v = 31'd1;
        5:       seed_v = 31'($urandom);
        default: seed_v = 31'($urandom_range(1, 2147483646));
      endcase
      load_seed(seed_v);
      no_idle = (ph == 2);
      for (int unsigned i = 0; i < PHASE_LEN; i++) begin
        if (ph == 1 && i == PHASE_LEN / 2) wait_drained();
        send_draw(random_draw(), 1'b0, '0);
      end
      no_idle = 1'b0;
    end

    // Drain and let the pipeline settle
    wait_drained();
    repeat (20) @(posedge clk_i);

    $display("Covered %0d draws: raw %0d, range %0d, bernoulli %0d, skip %0d",
             mode_hits[0] + mode_hits[1] + mode_hits[2] + mode_hits[3],
             mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3]);
    $display("Seed loads %0d, output words matched %0d, mismatches %0d",
             seed_loads, words_checked, err_count);
    if (err_count == 0 && value_queue.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
